// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions on i_clk, with or without the reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ----- hdl/rtw_pkg.sv -----
// ----------------------------------------------------------------------------
// rtw_pkg
// Sizes, word types, status codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package rtw_pkg;

    // FRAMES must be a power of two: table pointers reduce by masking.
    localparam int FRAMES     = 16;
    localparam int LEVELS     = 5;
    localparam int INDEX_BITS = 10;

    localparam int VPN_W      = 50;
    localparam int PFN_W      = 51;
    localparam int ENTRY_W    = PFN_W + 1;
    localparam int ROOT_W     = 4;
    localparam int FFREE_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int ADDR_W     = FRAME_BITS + INDEX_BITS;
    localparam int DEPTH      = FRAMES * (1 << INDEX_BITS);
    localparam int VA_BITS    = LEVELS * INDEX_BITS;
    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int FU_W       = $clog2(FRAMES + 1);
    localparam int NEXT_W     = ((FU_W > FFREE_W) ? FU_W : FFREE_W) + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOMAP    = 2'd1,
        ST_NOFRAMES = 2'd2
    } t_status;

    typedef struct packed {
        logic             mode;
        logic [VPN_W-1:0] virtual_page;
        logic [PFN_W-1:0] mapped_frame;
        logic             unmap;
    } t_in_word;

    typedef struct packed {
        t_status          status;
        logic [PFN_W-1:0] result_frame;
    } t_out_word;

    typedef struct packed {
        logic    clr_wr;
        logic    load;
        logic    rd;
        logic    step;
        logic    alloc;
        logic    leaf_wr;
        logic    set_res;
        logic    res_take;
        t_status res_status;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic unmap;
        logic entry_valid;
        logic at_leaf;
        logic dry;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/rtw_ctrl.sv -----
// ----------------------------------------------------------------------------
// rtw_ctrl
// Walk sequencer: memory clear, per-level read/evaluate, allocate, leaf write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtw_ctrl
    import rtw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if (!i_sts.is_query && i_sts.at_leaf) begin
                    o_cmd.leaf_wr    = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.entry_valid) begin
                    if (i_sts.is_query && i_sts.at_leaf) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_take   = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_READ;
                    end
                end else if (i_sts.is_query) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOMAP;
                    n_state          = S_DONE;
                end else if (i_sts.unmap) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_DONE;
                end else if (i_sts.dry) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOFRAMES;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.alloc = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_RST(a_eval_follows_read, r_state == S_EVAL |-> $past(r_state) == S_READ,
        "evaluate without a preceding read")
    `ASSERT_RST(a_accept_starts_walk, (i_in_valid && o_in_ready) |=> r_state == S_READ,
        "accepted word did not start a walk")

endmodule

// ----- hdl/rtw_datapath.sv -----
// ----------------------------------------------------------------------------
// rtw_datapath
// Frame memory, walk registers, bump allocator, configuration and result words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtw_datapath
    import rtw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_word              i_in_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output t_out_word             o_out_word
);

    localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(LEVELS - 1);

    logic [ENTRY_W-1:0]    mem [DEPTH];

    logic                  r_mode;
    logic                  r_unmap;
    logic [PFN_W-1:0]      r_mframe;
    logic [VA_BITS-1:0]    r_vpage;
    logic [FRAME_BITS-1:0] r_frame;
    logic [LVL_W-1:0]      r_level;
    logic [ADDR_W-1:0]     r_addr;
    logic [ENTRY_W-1:0]    r_rd_data;
    logic [FU_W-1:0]       r_frames_used;
    logic [ROOT_W-1:0]     r_root;
    logic [FFREE_W-1:0]    r_first_free;
    logic [ADDR_W-1:0]     r_clr_addr;
    t_out_word             r_res;
    t_out_word             r_out_word;
    logic                  r_out_valid;

    logic [INDEX_BITS-1:0] idx;
    logic [ADDR_W-1:0]     slot_addr;
    logic [NEXT_W-1:0]     next_frame;
    logic                  dry;
    logic [PFN_W-1:0]      entry_pfn;
    logic                  mem_we;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]    wr_data;

    // Table pointers are taken modulo the frame count.
    function automatic logic [FRAME_BITS-1:0] frame_ptr(input logic [PFN_W-1:0] f);
        return f[FRAME_BITS-1:0];
    endfunction

    assign idx        = r_vpage[VA_BITS-1 -: INDEX_BITS];
    assign slot_addr  = {r_frame, idx};
    assign next_frame = NEXT_W'(r_first_free) + NEXT_W'(r_frames_used);
    assign dry        = (next_frame >= NEXT_W'(FRAMES));
    assign entry_pfn  = r_rd_data[ENTRY_W-1:1];

    assign o_sts.clr_last    = &r_clr_addr;
    assign o_sts.is_query    = !r_mode;
    assign o_sts.unmap       = r_unmap;
    assign o_sts.entry_valid = r_rd_data[0];
    assign o_sts.at_leaf     = (r_level == LAST_LEVEL);
    assign o_sts.dry         = dry;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign mem_we = i_cmd.clr_wr || i_cmd.alloc || i_cmd.leaf_wr;

    always_comb begin
        if (i_cmd.clr_wr) begin
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (i_cmd.alloc) begin
            wr_addr = r_addr;
            wr_data = {PFN_W'(next_frame), 1'b1};
        end else begin
            wr_addr = slot_addr;
            wr_data = r_unmap ? '0 : {r_mframe, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[slot_addr];
        end
    end

    // Walk registers: payload only, no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_in_word.mode;
            r_unmap  <= i_in_word.unmap;
            r_mframe <= i_in_word.mapped_frame;
            r_vpage  <= VA_BITS'({{VA_BITS{1'b0}}, i_in_word.virtual_page});
            r_frame  <= frame_ptr(PFN_W'(r_root));
            r_level  <= '0;
        end else if (i_cmd.step || i_cmd.alloc) begin
            r_vpage <= r_vpage << INDEX_BITS;
            r_level <= r_level + LVL_W'(1);
            r_frame <= i_cmd.alloc ? next_frame[FRAME_BITS-1:0] : frame_ptr(entry_pfn);
        end
        if (i_cmd.rd) begin
            r_addr <= slot_addr;
        end
        if (i_cmd.set_res) begin
            r_res.status       <= i_cmd.res_status;
            r_res.result_frame <= i_cmd.res_take ? entry_pfn : '0;
        end
        if (i_cmd.out_load) begin
            r_out_word <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_used <= '0;
            r_root        <= '0;
            r_first_free  <= FFREE_W'(1);
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.alloc) begin
                r_frames_used <= r_frames_used + FU_W'(1);
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROOT_FRAME: r_root       <= i_cfg_data[ROOT_W-1:0];
                    CFG_FIRST_FREE: r_first_free <= i_cfg_data[FFREE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_RST(a_frames_bounded, r_frames_used <= FU_W'(FRAMES),
        "allocator count ran past the frame count")
    `ASSERT_RST(a_alloc_not_dry, i_cmd.alloc |-> !dry,
        "allocation issued with the allocator dry")

endmodule

// ----- hdl/radix_translation_walker.sv -----
// A query reads and evaluates each level in turn, then passes DONE and hands off the result.
// An update reads and evaluates each intermediate level, writes the leaf, then passes DONE and hands off.
// Throughput: one word at a time; the walk's dependent reads of the single-port memory set it.
// Reset: synchronous active low; then a clearing pass over all FRAMES*2^INDEX_BITS entries
// (16384) zeroes the frame memory while input stays blocked; config writes are taken.
// ----------------------------------------------------------------------------
// radix_translation_walker
// Multilevel radix translation walker over a local frame memory, with
// lookup, map and unmap, and a bump allocator for intermediate tables.
// ----------------------------------------------------------------------------
module radix_translation_walker
    import rtw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Configuration writes go straight into their registers; always take them.
    assign o_cfg_ready = 1'b1;

    // Sequencer: clear sweep, then read/evaluate per level, allocate or
    // write the leaf, and hold the result until the output word is free.
    rtw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Memory, walk pointer, allocator and the output word register, which
    // parts the result side from the walk so a new word can enter early.
    rtw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radix translation walker. Queries, maps and
// unmaps go in through the input channel. A local copy of the frame memory,
// the bump allocator and the registers predicts every result word. Each
// result word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import rtw_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 400000;  // clearing pass plus ~1000 walks, many times over
    localparam int SETTLE_CYCLES = 16;      // settling margin once every result is back
    localparam int RX_HOLD       = 400;     // long receiver hold-off, in cycles
    localparam int IDLE_PCT      = 18;
    localparam int POOL_MAX      = 48;
    localparam int TOP_SHIFT     = (LEVELS - 1) * INDEX_BITS;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs: every input is known from time zero
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_word   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_ready;
    logic                  out_valid;
    t_out_word             out_word;
    logic                  cfg_ready;

    always #CLK_HALF clk = ~clk;

    radix_translation_walker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: frame memory, allocator count and registers
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0]  frame_mem [DEPTH];
    int unsigned         frames_taken;
    logic [ROOT_W-1:0]   root_reg;
    logic [FFREE_W-1:0]  first_free_reg;

    t_out_word           pending_results [$];
    logic [VPN_W-1:0]    page_pool [$];      // pages mapped so far, for deep walks
    int                  mismatch_count = 0;
    int                  result_count   = 0;
    int                  cycle_count    = 0;

    // Idling switches and the receiver hold-off request counter
    bit                  in_idle_on  = 1'b1;
    bit                  out_idle_on = 1'b1;
    int                  hold_reqs   = 0;
    int                  hold_seen   = 0;
    int                  hold_left   = 0;

    t_out_word           rx_want;

    function automatic void reset_shadow();
        foreach (frame_mem[i]) frame_mem[i] = '0;
        frames_taken   = 0;
        root_reg       = '0;
        first_free_reg = FFREE_W'(1);
    endfunction

    // Table pointers are reduced modulo FRAMES; the index comes from the top down.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [PFN_W-1:0] frame,
                                                    input logic [VPN_W-1:0] vp,
                                                    input int lvl);
        logic [VPN_W-1:0] shifted;
        shifted = vp >> (INDEX_BITS * (LEVELS - 1 - lvl));
        return {frame[FRAME_BITS-1:0], shifted[INDEX_BITS-1:0]};
    endfunction

    // Walk the shadow tables for one input word; update it the way the block must.
    function automatic t_out_word walk_tables(input t_in_word w);
        t_out_word         r;
        logic [PFN_W-1:0]  frame;
        logic [ADDR_W-1:0] slot;
        int unsigned       next;
        r.status       = ST_OK;
        r.result_frame = '0;
        frame          = PFN_W'(root_reg);
        if (!w.mode) begin
            for (int lvl = 0; lvl < LEVELS; lvl++) begin
                slot = slot_addr(frame, w.virtual_page, lvl);
                if (!frame_mem[slot][0]) begin
                    r.status = ST_NOMAP;
                    return r;
                end
                frame = frame_mem[slot][ENTRY_W-1:1];
            end
            r.result_frame = frame;
            return r;
        end
        for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
            slot = slot_addr(frame, w.virtual_page, lvl);
            if (!frame_mem[slot][0]) begin
                // an unmap never allocates: a missing level ends it quietly
                if (w.unmap) return r;
                next = first_free_reg + frames_taken;
                if (next >= FRAMES) begin
                    // tables taken earlier in this walk stay in place
                    r.status = ST_NOFRAMES;
                    return r;
                end
                frames_taken++;
                frame_mem[slot] = {PFN_W'(next), 1'b1};
            end
            frame = frame_mem[slot][ENTRY_W-1:1];
        end
        slot = slot_addr(frame, w.virtual_page, LEVELS - 1);
        frame_mem[slot] = w.unmap ? '0 : {w.mapped_frame, 1'b1};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // Offer one word; hold valid and payload until it is taken. Valid is left
    // high after acceptance so the next word can follow without a bubble.
    task automatic send_word(input t_in_word w);
        t_out_word want;
        while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        want = walk_tables(w);
        pending_results.push_back(want);
        if (w.mode && !w.unmap && want.status == ST_OK) begin
            if (page_pool.size() >= POOL_MAX)
                page_pool.delete($urandom_range(page_pool.size() - 1));
            page_pool.push_back(w.virtual_page);
        end
    endtask

    // Drop valid, wait for every pending result, then let the pipe settle.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold the write until it is taken; valid stays up for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_ROOT_FRAME: root_reg       = data[ROOT_W-1:0];
            CFG_FIRST_FREE: first_free_reg = data;
            default: ;
        endcase
    endtask

    // Reprogram both registers with the block idle.
    task automatic program_regs(input int root, input int ffree);
        quiesce();
        write_reg(CFG_ROOT_FRAME, CFG_DATA_W'(root));
        write_reg(CFG_FIRST_FREE, CFG_DATA_W'(ffree));
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word make_word(input logic mode, input logic [VPN_W-1:0] vp,
                                           input logic [PFN_W-1:0] mf, input logic unmap);
        t_in_word w;
        w.mode         = mode;
        w.virtual_page = vp;
        w.mapped_frame = mf;
        w.unmap        = unmap;
        return w;
    endfunction

    function automatic logic [VPN_W-1:0] known_page();
        if (page_pool.size() == 0) return VPN_W'({$urandom, $urandom});
        return page_pool[$urandom_range(page_pool.size() - 1)];
    endfunction

    // Build a page from indices of known pages, level by level, so that walks
    // cross paths and run through shared tables; now and then a fresh index.
    function automatic logic [VPN_W-1:0] mixed_page();
        logic [VPN_W-1:0]      vp;
        logic [VPN_W-1:0]      src;
        logic [INDEX_BITS-1:0] ix;
        vp = '0;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            if (page_pool.size() == 0 || $urandom_range(99) < 15) begin
                ix = INDEX_BITS'($urandom);
            end else begin
                src = page_pool[$urandom_range(page_pool.size() - 1)];
                src = src >> (INDEX_BITS * (LEVELS - 1 - lvl));
                ix  = src[INDEX_BITS-1:0];
            end
            vp[INDEX_BITS * (LEVELS - 1 - lvl) +: INDEX_BITS] = ix;
        end
        return vp;
    endfunction

    function automatic t_in_word random_word();
        t_in_word         w;
        int               pick;
        logic [PFN_W-1:0] mf;
        logic [VPN_W-1:0] vp;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0:       mf = PFN_W'($urandom_range(FRAMES - 1));
            1:       mf = {PFN_W{1'b1}};
            default: mf = PFN_W'({$urandom, $urandom});
        endcase
        vp = ($urandom_range(1)) ? known_page() : mixed_page();
        if (pick < 20)
            // noise: any field, any value
            w = make_word(1'($urandom), VPN_W'({$urandom, $urandom}), mf, 1'($urandom));
        else if (pick < 55)
            w = make_word(1'b0, vp, mf, 1'($urandom));
        else if (pick < 85)
            w = make_word(1'b1, vp, mf, 1'b0);
        else
            w = make_word(1'b1, vp, mf, 1'b1);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready with random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = RX_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else if (out_idle_on) begin
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("tb: result %0d: %s: got 0x%0h, want 0x%0h", result_count, what, got, want);
    endtask

    // Compare every accepted result word with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(out_word), 64'd0);
            end else begin
                rx_want = pending_results.pop_front();
                if (out_word.status !== rx_want.status)
                    report_mismatch("status", 64'(out_word.status), 64'(rx_want.status));
                if (out_word.result_frame !== rx_want.result_frame)
                    report_mismatch("result_frame", 64'(out_word.result_frame),
                                    64'(rx_want.result_frame));
            end
            result_count++;
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Directed walk through the extremes and every special case.
    task automatic test_directed();
        logic [VPN_W-1:0] ones_vp;
        logic [PFN_W-1:0] ones_pf;
        ones_vp = {VPN_W{1'b1}};
        ones_pf = {PFN_W{1'b1}};
        program_regs(0, 1);
        // empty tables: nothing maps; mapped_frame and unmap are ignored on a query
        send_word(make_word(1'b0, '0, '0, 1'b0));
        send_word(make_word(1'b0, ones_vp, ones_pf, 1'b1));
        // unmap with the top level missing: no allocation, status ok
        send_word(make_word(1'b1, '0, '0, 1'b1));
        // map allocates four tables, then read it back
        send_word(make_word(1'b1, '0, ones_pf, 1'b0));
        send_word(make_word(1'b0, '0, '0, 1'b0));
        // neighbor on the same path: no allocation
        send_word(make_word(1'b1, VPN_W'(1), '0, 1'b0));
        send_word(make_word(1'b0, VPN_W'(1), '0, 1'b0));
        send_word(make_word(1'b1, ones_vp, PFN_W'({(PFN_W+1)/2{2'b10}}), 1'b0));
        send_word(make_word(1'b0, ones_vp, '0, 1'b0));
        // unmap a live leaf, then query both it and its neighbor
        send_word(make_word(1'b1, '0, ones_pf, 1'b1));
        send_word(make_word(1'b0, '0, '0, 1'b0));
        send_word(make_word(1'b0, VPN_W'(1), '0, 1'b0));

        // allocator dry from the start: new top index fails, existing path works
        program_regs(0, FRAMES);
        send_word(make_word(1'b1, VPN_W'(5) << TOP_SHIFT, ones_pf, 1'b0));
        send_word(make_word(1'b1, VPN_W'(2), PFN_W'(3), 1'b0));
        send_word(make_word(1'b1, VPN_W'(7) << TOP_SHIFT, '0, 1'b1));
        send_word(make_word(1'b0, VPN_W'(2), '0, 1'b0));

        // lower first_free: the used count is kept, so new tables alias old ones
        program_regs(15, 0);
        send_word(make_word(1'b1, {(VPN_W+1)/2{2'b01}}, PFN_W'(9), 1'b0));
        send_word(make_word(1'b0, {(VPN_W+1)/2{2'b01}}, '0, 1'b0));
        send_word(make_word(1'b0, ones_vp, '0, 1'b0));

        // allocator runs dry part way down a walk; upper tables stay
        program_regs(3, 2);
        send_word(make_word(1'b1, VPN_W'(10'h200) << TOP_SHIFT, ones_pf, 1'b0));
        send_word(make_word(1'b0, VPN_W'(10'h200) << TOP_SHIFT, '0, 1'b0));
        send_word(make_word(1'b1, VPN_W'(10'h200) << TOP_SHIFT, ones_pf, 1'b1));
    endtask

    // Random words over several register settings, the extremes among them.
    task automatic test_random_phases();
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       program_regs(15, FRAMES);
                1:       program_regs(0, 0);
                default: program_regs($urandom_range(15), $urandom_range(FRAMES));
            endcase
            repeat (150) send_word(random_word());
        end
    endtask

    // Long stretch with no idling on either side.
    task automatic test_no_idle();
        program_regs($urandom_range(15), $urandom_range(FRAMES));
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        repeat (150) send_word(random_word());
        quiesce();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // Hold the receiver off while words keep coming, so the block stalls its input.
    task automatic test_receiver_hold();
        in_idle_on = 1'b0;
        hold_reqs++;
        repeat (40) send_word(random_word());
        in_idle_on = 1'b1;
        quiesce();
    endtask

    // Short bursts, each followed by a pause until every result is back.
    task automatic test_sender_pause();
        for (int b = 0; b < 10; b++) begin
            repeat ($urandom_range(12, 1)) send_word(random_word());
            quiesce();
        end
    endtask

    initial begin
        reset_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_phases();
        test_no_idle();
        test_receiver_hold();
        test_sender_pause();
        quiesce();
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/rtw_pkg.sv
hdl/rtw_ctrl.sv
hdl/rtw_datapath.sv
hdl/radix_translation_walker.sv
tb/sv/tb.sv
